/* rtl/core/fcsi_pkg.sv */
// Shared types and constants of the fan curve core.
package fcsi_pkg;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_EVAL  = 1'b1
  } op_e;

  typedef enum logic {
    MODE_STEP   = 1'b0,
    MODE_LINEAR = 1'b1
  } mode_e;

  // Register index, taken from paddr[2]
  typedef enum logic {
    REG_CURVE_MODE  = 1'b0,
    REG_POINT_COUNT = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LAST,
    ST_FIRST,
    ST_SCAN,
    ST_MUL,
    ST_DIV,
    ST_INTERP,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    RES_RD,
    RES_FIRST,
    RES_LAST,
    RES_LOW,
    RES_INTERP
  } res_sel_e;

  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned DIV_CNT_W = 5;

  typedef struct packed {
    logic     wr_pt;
    logic     start;
    logic     ld_last;
    logic     ld_first;
    logic     ld_low;
    logic     ld_high;
    logic     mul;
    logic     div_step;
    logic     ld_res;
    res_sel_e res_sel;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic x_gt_rd;
    logic x_lt_rd;
    logic x_ge_last;
  } status_t;

endpackage

/* rtl/core/fcsi_in_if.sv */
// Input channel: breakpoint write and sample evaluate items.
interface fcsi_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [3:0]         point_index;
  logic signed [15:0] point_reading;
  logic [15:0]        point_output;
  logic signed [15:0] sample;

  modport source (
    output valid, operation, point_index, point_reading, point_output, sample,
    input  ready
  );
  modport sink (
    input  valid, operation, point_index, point_reading, point_output, sample,
    output ready
  );
endinterface

/* rtl/core/fcsi_out_if.sv */
// Output channel: drive value results.
interface fcsi_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] drive_value;

  modport source (output valid, drive_value, input ready);
  modport sink (input valid, drive_value, output ready);
endinterface

/* rtl/core/fcsi_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module fcsi_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/fcsi_cfg.sv */
// Configuration registers behind the APB-style port.
module fcsi_cfg #(
  parameter int unsigned MAX_POINTS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output logic                          curve_mode_o,
  output logic [$clog2(MAX_POINTS)-1:0] last_idx_o
);

  localparam int unsigned AW = $clog2(MAX_POINTS);

  logic       mode_q, mode_d;
  logic [4:0] count_q, count_d;
  logic       wr_en;
  logic [6:0] cnt_ext, n_use, last_ext;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    mode_d  = mode_q;
    count_d = count_q;
    if (wr_en) begin
      unique case (fcsi_pkg::reg_idx_e'(paddr[2]))
        fcsi_pkg::REG_CURVE_MODE:  mode_d  = pwdata[0];
        fcsi_pkg::REG_POINT_COUNT: count_d = pwdata[4:0];
        default:                   mode_d  = mode_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= fcsi_pkg::MODE_STEP;
      count_q <= 5'd1;
    end else begin
      mode_q  <= mode_d;
      count_q <= count_d;
    end
  end

  always_comb begin
    unique case (fcsi_pkg::reg_idx_e'(paddr[2]))
      fcsi_pkg::REG_CURVE_MODE:  prdata = {31'd0, mode_q};
      fcsi_pkg::REG_POINT_COUNT: prdata = {27'd0, count_q};
      default:                   prdata = 32'd0;
    endcase
  end

  // Zero counts as one point, anything past the table saturates
  assign cnt_ext = {2'b00, count_q};
  always_comb begin
    priority if (count_q == 5'd0) begin
      n_use = 7'd1;
    end else if (cnt_ext > 7'(MAX_POINTS)) begin
      n_use = 7'(MAX_POINTS);
    end else begin
      n_use = cnt_ext;
    end
  end
  assign last_ext     = n_use - 7'd1;
  assign last_idx_o   = last_ext[AW-1:0];
  assign curve_mode_o = mode_q;

endmodule

/* rtl/core/fcsi_ctrl.sv */
// Sequencer: table scan, multiply and serial divide control, output register.
module fcsi_ctrl #(
  parameter int unsigned MAX_POINTS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_op_i,
  output logic                          in_ready_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  input  logic                          curve_mode_i,
  input  logic [$clog2(MAX_POINTS)-1:0] last_idx_i,
  input  fcsi_pkg::status_t             status_i,
  output fcsi_pkg::cmd_t                cmd_o,
  output logic [$clog2(MAX_POINTS)-1:0] rd_addr_o
);

  localparam int unsigned AW = $clog2(MAX_POINTS);

  fcsi_pkg::state_e                 state_q, state_d;
  logic [AW-1:0]                    idx_q, idx_d;
  logic [fcsi_pkg::DIV_CNT_W-1:0]   cnt_q, cnt_d;
  logic                             out_valid_q, out_valid_d;
  logic                             linear;
  logic                             at_last;

  assign linear  = (curve_mode_i == fcsi_pkg::MODE_LINEAR);
  assign at_last = (idx_q == last_idx_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fcsi_pkg::ST_IDLE;
      idx_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    rd_addr_o  = idx_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      fcsi_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        rd_addr_o  = last_idx_i;
        if (in_valid_i) begin
          if (in_op_i == fcsi_pkg::OP_EVAL) begin
            cmd_o.start = 1'b1;
            state_d     = fcsi_pkg::ST_LAST;
          end else begin
            cmd_o.wr_pt = 1'b1;
          end
        end
      end
      fcsi_pkg::ST_LAST: begin
        cmd_o.ld_last = 1'b1;
        rd_addr_o     = '0;
        state_d       = fcsi_pkg::ST_FIRST;
      end
      fcsi_pkg::ST_FIRST: begin
        rd_addr_o = AW'(1);
        priority if (linear && status_i.x_ge_last) begin
          cmd_o.ld_res  = 1'b1;
          cmd_o.res_sel = fcsi_pkg::RES_LAST;
          state_d       = fcsi_pkg::ST_DONE;
        end else if (!status_i.x_gt_rd || last_idx_i == '0) begin
          cmd_o.ld_res  = 1'b1;
          cmd_o.res_sel = fcsi_pkg::RES_RD;
          state_d       = fcsi_pkg::ST_DONE;
        end else begin
          cmd_o.ld_first = 1'b1;
          idx_d          = AW'(1);
          state_d        = fcsi_pkg::ST_SCAN;
        end
      end
      fcsi_pkg::ST_SCAN: begin
        // prefetch the next slot; hold the address on the last one
        rd_addr_o = at_last ? idx_q : idx_q + AW'(1);
        priority if (status_i.x_lt_rd) begin
          if (linear) begin
            cmd_o.ld_high = 1'b1;
            state_d       = fcsi_pkg::ST_MUL;
          end else begin
            cmd_o.ld_res  = 1'b1;
            cmd_o.res_sel = fcsi_pkg::RES_LOW;
            state_d       = fcsi_pkg::ST_DONE;
          end
        end else if (at_last) begin
          // linear: nothing brackets the sample, fall back to the first output
          cmd_o.ld_res  = 1'b1;
          cmd_o.res_sel = linear ? fcsi_pkg::RES_FIRST : fcsi_pkg::RES_RD;
          state_d       = fcsi_pkg::ST_DONE;
        end else begin
          cmd_o.ld_low = 1'b1;
          idx_d        = idx_q + AW'(1);
        end
      end
      fcsi_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        cnt_d     = '0;
        state_d   = fcsi_pkg::ST_DIV;
      end
      fcsi_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == fcsi_pkg::DIV_CNT_W'(fcsi_pkg::DIV_STEPS - 1)) begin
          state_d = fcsi_pkg::ST_INTERP;
        end
      end
      fcsi_pkg::ST_INTERP: begin
        cmd_o.ld_res  = 1'b1;
        cmd_o.res_sel = fcsi_pkg::RES_INTERP;
        state_d       = fcsi_pkg::ST_DONE;
      end
      fcsi_pkg::ST_DONE: begin
        // wait for the output register to drain
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = fcsi_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fcsi_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* rtl/core/fcsi_dp.sv */
// Datapath: breakpoint RAM, bracket registers, multiplier and serial divider.
module fcsi_dp #(
  parameter int unsigned MAX_POINTS = 16
) (
  input  logic                          clk_i,
  input  fcsi_pkg::cmd_t                cmd_i,
  input  logic [3:0]                    point_index_i,
  input  logic signed [15:0]            point_reading_i,
  input  logic [15:0]                   point_output_i,
  input  logic signed [15:0]            sample_i,
  input  logic [$clog2(MAX_POINTS)-1:0] rd_addr_i,
  output fcsi_pkg::status_t             status_o,
  output logic [15:0]                   drive_value_o
);

  localparam int unsigned AW = $clog2(MAX_POINTS);

  logic [7:0]         idx_ext;
  logic               wr_en;
  logic [31:0]        rdata;
  logic signed [15:0] rd_rd;
  logic [15:0]        rd_out;

  logic signed [15:0] x_q;
  logic [15:0]        last_out_q, first_out_q, low_out_q;
  logic signed [15:0] low_rd_q;
  logic               x_ge_last_q;
  logic [15:0]        mag_q, dx_q, den_q;
  logic               neg_q;
  logic [31:0]        quo_q;
  logic [15:0]        rem_q;
  logic [15:0]        res_q, out_q;

  logic               neg_d;
  logic [15:0]        mag_d;
  logic signed [16:0] dx_full, den_full;
  logic [16:0]        shifted, trial;
  logic               fits;
  logic [16:0]        interp;

  // drop writes to slots past the table
  assign idx_ext = {4'd0, point_index_i};
  assign wr_en   = cmd_i.wr_pt && (idx_ext < 8'(MAX_POINTS));

  fcsi_ram #(
    .WIDTH(32),
    .DEPTH(MAX_POINTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(idx_ext[AW-1:0]),
    .wdata_i({point_reading_i, point_output_i}),
    .raddr_i(rd_addr_i),
    .rdata_o(rdata)
  );

  assign rd_rd  = rdata[31:16];
  assign rd_out = rdata[15:0];

  assign status_o.x_gt_rd   = (x_q > rd_rd);
  assign status_o.x_lt_rd   = (x_q < rd_rd);
  assign status_o.x_ge_last = x_ge_last_q;

  // bracket differences, none negative once the bracket is found
  assign neg_d    = (rd_out < low_out_q);
  assign mag_d    = neg_d ? (low_out_q - rd_out) : (rd_out - low_out_q);
  assign dx_full  = {x_q[15], x_q} - {low_rd_q[15], low_rd_q};
  assign den_full = {rd_rd[15], rd_rd} - {low_rd_q[15], low_rd_q};

  // restoring divide, one quotient bit per step
  assign shifted = {rem_q, quo_q[31]};
  assign trial   = shifted - {1'b0, den_q};
  assign fits    = (shifted >= {1'b0, den_q});

  assign interp = neg_q ? ({1'b0, low_out_q} - {1'b0, quo_q[15:0]})
                        : ({1'b0, low_out_q} + {1'b0, quo_q[15:0]});

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      x_q <= sample_i;
    end
    if (cmd_i.ld_last) begin
      last_out_q  <= rd_out;
      x_ge_last_q <= !(x_q < rd_rd);
    end
    if (cmd_i.ld_first) begin
      first_out_q <= rd_out;
    end
    if (cmd_i.ld_first || cmd_i.ld_low) begin
      low_rd_q  <= rd_rd;
      low_out_q <= rd_out;
    end
    if (cmd_i.ld_high) begin
      neg_q <= neg_d;
      mag_q <= mag_d;
      dx_q  <= dx_full[15:0];
      den_q <= den_full[15:0];
    end
    if (cmd_i.mul) begin
      quo_q <= mag_q * dx_q;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[30:0], fits};
      rem_q <= fits ? trial[15:0] : shifted[15:0];
    end
    if (cmd_i.ld_res) begin
      unique case (cmd_i.res_sel)
        fcsi_pkg::RES_RD:     res_q <= rd_out;
        fcsi_pkg::RES_FIRST:  res_q <= first_out_q;
        fcsi_pkg::RES_LAST:   res_q <= last_out_q;
        fcsi_pkg::RES_LOW:    res_q <= low_out_q;
        fcsi_pkg::RES_INTERP: res_q <= interp[15:0];
        default:              res_q <= rd_out;
      endcase
    end
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  assign drive_value_o = out_q;

endmodule

/* rtl/core/fan_curve_step_or_interpolate_core.sv */
// Top level of the fan curve core: breakpoint table lookup and interpolation.
//
// Items arrive on in_if_i. A write item (operation 0) loads one breakpoint,
// a signed Q12.4 reading and an unsigned output, into slot point_index and
// gives no result. An evaluate item (operation 1) maps sample through the
// first point_count points and gives one drive_value on out_if_o. Registers
// curve_mode (byte 0) and point_count (byte 4) sit on the APB-style port;
// write them only while the core is idle.
// An evaluate item walks the table through the single read port of the
// breakpoint RAM, one slot per cycle. Step mode finishes after the scan;
// linear mode adds a multiply and a restoring divide. The core takes one
// item at a time. The result sits in an output register; the core accepts
// further items while it waits, and stalls only when a second result is
// ready before the first is taken. Reset clears the control state and sets
// curve_mode to step and point_count to 1; table slots hold nothing defined
// until written.
module fan_curve_step_or_interpolate_core #(
  parameter int unsigned MAX_POINTS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  fcsi_in_if.sink           in_if_i,
  fcsi_out_if.source        out_if_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int unsigned AW = $clog2(MAX_POINTS);

  logic              curve_mode;
  logic [AW-1:0]     last_idx;
  logic [AW-1:0]     rd_addr;
  fcsi_pkg::cmd_t    cmd;
  fcsi_pkg::status_t status;

  fcsi_cfg #(
    .MAX_POINTS(MAX_POINTS)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .curve_mode_o(curve_mode),
    .last_idx_o  (last_idx)
  );

  fcsi_ctrl #(
    .MAX_POINTS(MAX_POINTS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if_i.valid),
    .in_op_i     (in_if_i.operation),
    .in_ready_o  (in_if_i.ready),
    .out_valid_o (out_if_o.valid),
    .out_ready_i (out_if_o.ready),
    .curve_mode_i(curve_mode),
    .last_idx_i  (last_idx),
    .status_i    (status),
    .cmd_o       (cmd),
    .rd_addr_o   (rd_addr)
  );

  fcsi_dp #(
    .MAX_POINTS(MAX_POINTS)
  ) u_dp (
    .clk_i          (clk_i),
    .cmd_i          (cmd),
    .point_index_i  (in_if_i.point_index),
    .point_reading_i(in_if_i.point_reading),
    .point_output_i (in_if_i.point_output),
    .sample_i       (in_if_i.sample),
    .rd_addr_i      (rd_addr),
    .status_o       (status),
    .drive_value_o  (out_if_o.drive_value)
  );

endmodule

/* tb/fan_curve_step_or_interpolate_core_tb.sv */
// Testbench of the fan curve core: directed table, then random tables checked by a predictor.
`timescale 1ns / 100ps

module fan_curve_step_or_interpolate_core_tb;

  localparam int SLOTS        = 16;
  localparam int DRAIN_CYCLES = 80;
  localparam int PHASES       = 14;
  localparam int PHASE_ITEMS  = 60;

  typedef enum {ROW_CFG, ROW_WRITE, ROW_EVAL} row_kind_e;

  typedef struct {
    row_kind_e           kind;
    fcsi_pkg::reg_idx_e  regsel;
    logic [31:0]         value;
    logic [3:0]          slot;
    logic signed [15:0]  reading;
    logic [15:0]         outv;
    logic signed [15:0]  smp;
    bit                  known;
    logic [15:0]         want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  fcsi_in_if  in_if ();
  fcsi_out_if out_if ();

  fan_curve_step_or_interpolate_core #(
    .MAX_POINTS(SLOTS)
  ) i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if_i (in_if),
    .out_if_o(out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk_i = ~clk_i;

  // Breakpoint table and register mirror
  logic signed [15:0] bp_reading [SLOTS];
  logic [15:0]        bp_output [SLOTS];
  fcsi_pkg::mode_e    curve_mode_m;
  logic [4:0]         point_count_m;

  logic [15:0] drive_expect_q [$];
  int          errors = 0;
  bit          quiet  = 1'b0;
  row_t        dir_q [$];

  task automatic flag_error(string msg);
    $display("ERROR: %s at %0t", msg, $time);
    errors++;
  endtask

  function automatic logic [15:0] predict_drive(logic signed [15:0] x);
    int          n;
    logic [15:0] v;
    bit          done;
    longint      xl, xh, yl, yh, q;
    n = (point_count_m == 0) ? 1 : ((point_count_m > SLOTS) ? SLOTS : point_count_m);
    v = bp_output[0];
    done = 1'b0;
    if (curve_mode_m == fcsi_pkg::MODE_STEP) begin
      if (x > bp_reading[0]) begin
        for (int i = 1; i < n; i++) begin
          if (!done) begin
            if (bp_reading[i] > x) done = 1'b1;
            else v = bp_output[i];
          end
        end
      end
      return v;
    end
    if (x >= bp_reading[n-1]) return bp_output[n-1];
    if (x > bp_reading[0]) begin
      for (int i = 1; i < n; i++) begin
        if (!done && bp_reading[i] > x) begin
          done = 1'b1;
          xl = bp_reading[i-1];
          xh = bp_reading[i];
          yl = bp_output[i-1];
          yh = bp_output[i];
          if (xh - xl <= 0) begin
            v = bp_output[0];
          end else begin
            q = yl + ((yh - yl) * (longint'(x) - xl)) / (xh - xl);
            if (q < 0) q = 0;
            if (q > 65535) q = 65535;
            v = q[15:0];
          end
        end
      end
    end
    return v;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic signed [15:0] pick_sample();
    int r, k, d, v, lo, hi;
    r = $urandom_range(0, 99);
    k = $urandom_range(0, SLOTS - 1);
    if (r < 50) begin
      d = $urandom_range(0, 6);
      v = bp_reading[k] + d - 3;
    end else if (r < 80) begin
      lo = bp_reading[k];
      hi = bp_reading[(k + 1) % SLOTS];
      if (lo > hi) begin
        d = lo;
        lo = hi;
        hi = d;
      end
      d = $urandom_range(0, hi - lo);
      v = lo + d;
    end else if (r < 95) begin
      return 16'($urandom);
    end else begin
      v = $urandom_range(0, 1) ? 32767 : -32768;
    end
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  task automatic send_item(fcsi_pkg::op_e op, logic [3:0] slot,
                           logic signed [15:0] reading,
                           logic [15:0] outv, logic signed [15:0] smp,
                           bit known, logic [15:0] want);
    int gap;
    @(negedge clk_i);
    in_if.valid         = 1'b1;
    in_if.operation     = op;
    in_if.point_index   = slot;
    in_if.point_reading = reading;
    in_if.point_output  = outv;
    in_if.sample        = smp;
    do @(posedge clk_i); while (!in_if.ready);
    if (op == fcsi_pkg::OP_WRITE) begin
      bp_reading[slot] = reading;
      bp_output[slot]  = outv;
    end else begin
      drive_expect_q.push_back(known ? want : predict_drive(smp));
    end
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_if.valid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // Drop valid, drain results, then give an evaluate still in flight time to finish
  task automatic wait_idle();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (drive_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(fcsi_pkg::reg_idx_e sel, logic [31:0] value);
    logic [31:0] back;
    logic [31:0] want;
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {sel, 2'b00};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (sel == fcsi_pkg::REG_CURVE_MODE) curve_mode_m = fcsi_pkg::mode_e'(value[0]);
    else point_count_m = value[4:0];
    @(negedge clk_i);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    back = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    if (sel == fcsi_pkg::REG_CURVE_MODE) begin
      want = {31'b0, curve_mode_m};
      back = {31'b0, back[0]};
    end else begin
      want = {27'b0, point_count_m};
      back = {27'b0, back[4:0]};
    end
    if (back !== want)
      flag_error($sformatf("register %s reads %h, expected %h", sel.name(), back, want));
  endtask

  function automatic row_t row_cfg(fcsi_pkg::reg_idx_e sel, logic [31:0] value);
    row_t r;
    r = '{kind: ROW_CFG, regsel: sel, value: value, default: '0};
    return r;
  endfunction

  function automatic row_t row_wr(logic [3:0] slot, logic signed [15:0] reading,
                                  logic [15:0] outv);
    row_t r;
    r = '{kind: ROW_WRITE, regsel: fcsi_pkg::REG_CURVE_MODE, slot: slot,
          reading: reading, outv: outv, default: '0};
    return r;
  endfunction

  function automatic row_t row_ev(logic signed [15:0] smp, bit known, logic [15:0] want);
    row_t r;
    r = '{kind: ROW_EVAL, regsel: fcsi_pkg::REG_CURVE_MODE, smp: smp, known: known,
          want: want, default: '0};
    return r;
  endfunction

  always @(posedge clk_i) begin : check_drive
    logic [15:0] want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (drive_expect_q.size() == 0) begin
        flag_error($sformatf("unexpected drive_value %h", out_if.drive_value));
      end else begin
        want = drive_expect_q.pop_front();
        if (out_if.drive_value !== want)
          flag_error($sformatf("drive_value %h, expected %h", out_if.drive_value, want));
      end
    end
  end

  // Result side: random stalls unless in a quiet stretch
  initial begin : drive_ready
    int stall_left;
    stall_left = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (quiet) begin
        out_if.ready = 1'b1;
      end else if (stall_left > 0) begin
        out_if.ready = 1'b0;
        stall_left--;
      end else begin
        out_if.ready = 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  initial begin : run_limit
    #15_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : stimulus
    int                 gap_max, acc, cnt;
    bit                 ascending, mode_bit;
    logic signed [15:0] rd;
    int                 count_pick [8] = '{0, 31, 17, 16, 1, 2, 16, 1};

    rst_ni              = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    in_if.valid         = 1'b0;
    in_if.operation     = fcsi_pkg::OP_WRITE;
    in_if.point_index   = '0;
    in_if.point_reading = '0;
    in_if.point_output  = '0;
    in_if.sample        = '0;
    curve_mode_m        = fcsi_pkg::MODE_STEP;
    point_count_m       = 5'd1;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Single point after reset: output of slot 0 everywhere
    dir_q.push_back(row_wr(4'd0, -16'sd32768, 16'hFFFF));
    dir_q.push_back(row_ev(-16'sd32768, 1'b1, 16'hFFFF));
    dir_q.push_back(row_ev(16'sd32767, 1'b1, 16'hFFFF));
    dir_q.push_back(row_cfg(fcsi_pkg::REG_CURVE_MODE, 32'(fcsi_pkg::MODE_LINEAR)));
    dir_q.push_back(row_ev(16'sd0, 1'b1, 16'hFFFF));
    dir_q.push_back(row_cfg(fcsi_pkg::REG_CURVE_MODE, 32'(fcsi_pkg::MODE_STEP)));
    // Four ascending points, last one at the top of the reading range
    dir_q.push_back(row_wr(4'd0, 16'sd0, 16'h1234));
    dir_q.push_back(row_wr(4'd1, 16'sd16, 16'd100));
    dir_q.push_back(row_wr(4'd2, 16'sd32, 16'd300));
    dir_q.push_back(row_wr(4'd3, 16'sd32767, 16'd0));
    dir_q.push_back(row_cfg(fcsi_pkg::REG_POINT_COUNT, 32'd4));
    dir_q.push_back(row_ev(-16'sd1, 1'b1, 16'h1234));
    dir_q.push_back(row_ev(16'sd0, 1'b1, 16'h1234));
    dir_q.push_back(row_ev(16'sd16, 1'b1, 16'd100));
    dir_q.push_back(row_ev(16'sd31, 1'b1, 16'd100));
    dir_q.push_back(row_ev(16'sd32767, 1'b1, 16'd0));
    dir_q.push_back(row_cfg(fcsi_pkg::REG_CURVE_MODE, 32'(fcsi_pkg::MODE_LINEAR)));
    dir_q.push_back(row_ev(16'sd32767, 1'b1, 16'd0));
    dir_q.push_back(row_ev(-16'sd32768, 1'b1, 16'h1234));
    dir_q.push_back(row_ev(16'sd8, 1'b0, '0));
    dir_q.push_back(row_ev(16'sd24, 1'b0, '0));
    dir_q.push_back(row_ev(16'sd32766, 1'b0, '0));
    // Table not ascending: a sample below both ends is not bracketed
    dir_q.push_back(row_wr(4'd0, 16'sd100, 16'd5));
    dir_q.push_back(row_wr(4'd1, 16'sd200, 16'd9));
    dir_q.push_back(row_wr(4'd2, -16'sd50, 16'd7));
    dir_q.push_back(row_cfg(fcsi_pkg::REG_POINT_COUNT, 32'd3));
    dir_q.push_back(row_ev(-16'sd60, 1'b1, 16'd5));
    dir_q.push_back(row_ev(16'sd150, 1'b1, 16'd7));
    // Widest span: full reading range against full output range
    dir_q.push_back(row_wr(4'd0, -16'sd32768, 16'd0));
    dir_q.push_back(row_wr(4'd1, 16'sd32767, 16'hFFFF));
    dir_q.push_back(row_cfg(fcsi_pkg::REG_POINT_COUNT, 32'd2));
    dir_q.push_back(row_ev(16'sd32766, 1'b0, '0));
    dir_q.push_back(row_ev(16'sd0, 1'b0, '0));

    foreach (dir_q[i]) begin
      case (dir_q[i].kind)
        ROW_CFG: begin
          wait_idle();
          cfg_write(dir_q[i].regsel, dir_q[i].value);
        end
        ROW_WRITE: begin
          send_item(fcsi_pkg::OP_WRITE, dir_q[i].slot, dir_q[i].reading, dir_q[i].outv,
                    16'($urandom), 1'b0, '0);
        end
        default: begin
          send_item(fcsi_pkg::OP_EVAL, 4'($urandom), 16'($urandom), 16'($urandom),
                    dir_q[i].smp, dir_q[i].known, dir_q[i].want);
        end
      endcase
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      quiet = (phase % 4 == 3);
      mode_bit = (phase < 8) ? phase[0] : 1'($urandom_range(0, 1));
      cnt = (phase < 8) ? count_pick[phase] : $urandom_range(1, SLOTS);
      cfg_write(fcsi_pkg::REG_CURVE_MODE, ($urandom & ~32'h1) | 32'(mode_bit));
      cfg_write(fcsi_pkg::REG_POINT_COUNT, ($urandom & ~32'h1F) | 32'(cnt));

      // Reload every slot so no evaluate touches an unwritten one
      ascending = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 2))
        0:       gap_max = 8;
        1:       gap_max = 300;
        default: gap_max = 4000;
      endcase
      acc = -32768 + int'($urandom_range(0, 65535 - 15 * gap_max));
      for (int k = 0; k < SLOTS; k++) begin
        rd = ascending ? acc[15:0] : 16'($urandom);
        send_item(fcsi_pkg::OP_WRITE, 4'(k), rd, 16'($urandom), 16'($urandom),
                  1'b0, '0);
        acc += ($urandom_range(0, 9) == 0) ? 0 : int'($urandom_range(1, gap_max));
      end

      for (int j = 0; j < PHASE_ITEMS; j++) begin
        if ($urandom_range(0, 9) == 0)
          send_item(fcsi_pkg::OP_WRITE, 4'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), 1'b0, '0);
        else
          send_item(fcsi_pkg::OP_EVAL, 4'($urandom), 16'($urandom), 16'($urandom),
                    pick_sample(), 1'b0, '0);
      end
    end

    wait_idle();
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/fcsi_pkg.sv
rtl/core/fcsi_in_if.sv
rtl/core/fcsi_out_if.sv
rtl/core/fcsi_ram.sv
rtl/core/fcsi_cfg.sv
rtl/core/fcsi_ctrl.sv
rtl/core/fcsi_dp.sv
rtl/core/fan_curve_step_or_interpolate_core.sv
tb/fan_curve_step_or_interpolate_core_tb.sv
